@@ rtl/core/vdl_pkg.sv @@
// Package for the vibrato delay line: sizing constants, register codes,
// the quarter-wave sine table and the LFO increment table.
// No dependencies; used by vdl_if.sv and vibrato_delay_line.sv.
package vdl_pkg;

  // Delay line
  localparam int LINE_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  // Audio and modulation constants
  localparam longint SAMPLE_RATE_HZ = 48000;
  localparam longint MAX_DELAY_MS   = 10;
  localparam int     SINE_DEPTH     = 256;
  localparam int     SINE_IDX_W     = $clog2(SINE_DEPTH);
  localparam int     POT_W          = 7;
  localparam logic [POT_W-1:0] POT_MAX = 7'd100;

  // Config register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_RATE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEPTH = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIX   = 2'd2;
  localparam logic [POT_W-1:0] MIX_RESET = 7'd50;

  // Greatest common divisor by repeated subtraction (both inputs positive)
  function automatic longint gcd_f(input longint a, input longint b);
    longint x;
    longint y;
    x = a;
    y = b;
    while (x != y) begin
      if (x > y) begin
        x = x - y;
      end else begin
        y = y - x;
      end
    end
    return x;
  endfunction

  // Swing = depth * SAMPLE_RATE_HZ * sine / 25000, reduced to NUM/DEN
  localparam longint SW_G    = gcd_f(SAMPLE_RATE_HZ, 25000);
  localparam longint SW_NUM  = SAMPLE_RATE_HZ / SW_G;
  localparam longint SW_DEN  = 25000 / SW_G;
  localparam longint SW_PROD_MAX = 100 * SW_NUM * 32767;
  localparam int     SW_PROD_W   = $clog2(SW_PROD_MAX + 1);
  localparam longint SW_MAX      = SW_PROD_MAX / SW_DEN + 1;

  // Final mix: (sum + 32768*100 + 50) / 100, always non-negative
  localparam longint MIX_BIAS  = 3276850;
  localparam int     MIX_DIV_W = 23;
  localparam int     MIX_DEN   = 100;

  // Shared serial divider
  localparam int DIV_W = (SW_PROD_W > MIX_DIV_W) ? SW_PROD_W : MIX_DIV_W;
  localparam int DVS_W = $clog2(((SW_DEN > MIX_DEN) ? SW_DEN : MIX_DEN) + 1);
  localparam int CNT_W = $clog2(((DIV_W > 16) ? DIV_W : 16) + 1);

  // Shift-add accumulator
  localparam int ACC_W = ((SW_PROD_W + 1) > 34) ? (SW_PROD_W + 1) : 34;
  localparam int MPL_W = 16;

  // Delay in Q.16 samples
  localparam longint CENTER_Q16 = (MAX_DELAY_MS * SAMPLE_RATE_HZ * 65536) / 2000;
  localparam int DLY_RAW_W = $clog2(CENTER_Q16 + SW_MAX + 1);
  localparam int DLY_W = ((DLY_RAW_W > (ADDR_W + 16)) ? DLY_RAW_W : (ADDR_W + 16)) + 2;
  localparam logic signed [DLY_W-1:0] DLY_CENTER = DLY_W'(CENTER_Q16);
  localparam logic signed [DLY_W-1:0] DLY_MIN    = DLY_W'(65536);
  localparam logic signed [DLY_W-1:0] DLY_MAX    = DLY_W'(longint'(LINE_DEPTH - 2) * 65536);
  localparam logic signed [DLY_W-1:0] DLY_WRAP   = DLY_W'(longint'(LINE_DEPTH) * 65536);

  // Quarter-wave sine, Taylor series in Q30
  localparam longint unsigned Q30_ONE     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

  typedef logic [14:0] sine_tab_t [0:SINE_DEPTH];
  typedef logic [31:0] inc_tab_t [0:100];

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x  = (HALF_PI_Q30 * longint'(k)) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      for (int n = 0; n < 5; n++) begin
        t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV[n]);
      end
      s = (x * t) >> 30;
      s = (s * 32767 + (64'd1 << 29)) >> 30;
      if (s > 32767) begin
        s = 32767;
      end
      tab[k] = 15'(s);
    end
    return tab;
  endfunction

  localparam longint unsigned INC_DEN = 100 * SAMPLE_RATE_HZ;

  function automatic inc_tab_t build_inc();
    inc_tab_t tab;
    longint unsigned num;
    for (int r = 0; r <= 100; r++) begin
      num    = longint'(50 + 8 * r) << 32;
      tab[r] = 32'((num + INC_DEN / 2) / INC_DEN);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();
  localparam inc_tab_t  INC_TAB  = build_inc();

  // Pots above full scale act as full scale
  function automatic logic [POT_W-1:0] pot_clamp(input logic [POT_W-1:0] p);
    return (p > POT_MAX) ? POT_MAX : p;
  endfunction

endpackage

@@ rtl/core/vdl_if.sv @@
// Handshake interfaces of the vibrato delay line: sample in, sample out,
// and the config write channel. Depends on vdl_pkg.
interface vdl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_in;
  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface vdl_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface vdl_cfg_if;
  import vdl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [POT_W-1:0]      wdata;
  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

@@ rtl/core/vdl_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module vdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/vibrato_delay_line.sv @@
// Vibrato delay line, top level. Depends on vdl_pkg, vdl_if, vdl_ram.
// One word at a time: a new input word is taken only in S_IDLE, after the last
// word has left S_OUT; the time per word is set by the bit-serial divider (two
// passes) and the shift-add multiplier (two passes).
// Reset (rst_n low, synchronous): phase, write pointer, pots cleared (mix 50);
// the delay line needs no clear pass, a fill mark makes unwritten taps read 0.
module vibrato_delay_line (
  input logic      clk,
  input logic      rst_n,
  vdl_in_if.sink   in_ch,
  vdl_out_if.source out_ch,
  vdl_cfg_if.sink  cfg_ch
);
  import vdl_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SINE = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_DLY  = 4'd4;
  localparam logic [3:0] S_PTR  = 4'd5;
  localparam logic [3:0] S_RD0  = 4'd6;
  localparam logic [3:0] S_RD1  = 4'd7;
  localparam logic [3:0] S_RD2  = 4'd8;
  localparam logic [3:0] S_WET  = 4'd9;
  localparam logic [3:0] S_MIX  = 4'd10;
  localparam logic [3:0] S_OUT  = 4'd11;

  // Control
  logic [3:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic              full_r, full_nxt;
  logic [31:0]       phase_r, phase_nxt;
  logic [POT_W-1:0]  rate_r, depth_r, mix_r;
  logic              mode_r, mode_nxt;   // 0: swing multiply, 1: interpolation
  logic              sel_r, sel_nxt;     // 0: divide by SW_DEN, 1: by 100
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Datapath
  logic signed [15:0]      dry_r, dry_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [ACC_W-1:0] mcand_r, mcand_nxt;
  logic signed [ACC_W-1:0] dmc_r, dmc_nxt;
  logic [MPL_W-1:0]        mplier_r, mplier_nxt;
  logic [DIV_W-1:0]        quo_r, quo_nxt;
  logic [DVS_W-1:0]        rem_r, rem_nxt;
  logic signed [DLY_W-1:0] dly_r, dly_nxt;
  logic [ADDR_W-1:0]       i0_r, i0_nxt;
  logic [15:0]             frac_r, frac_nxt;
  logic                    v_r, v_nxt;
  logic signed [15:0]      s0_r, s0_nxt;
  logic signed [15:0]      out_r, out_nxt;

  // RAM
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  // Temporaries
  logic                    in_acc;
  logic [1:0]              quad;
  logic [SINE_IDX_W:0]     sidx;
  logic [POT_W-1:0]        depth_c, mix_c, rate_c;
  logic [DVS_W:0]          rem_sh;
  logic [DVS_W-1:0]        dvs;
  logic signed [DLY_W-1:0] swing, dly_raw, pos;
  logic [ADDR_W-1:0]       i1;
  logic signed [15:0]      s1v;
  logic signed [16:0]      diff;
  logic signed [ACC_W-1:0] rnd;
  logic signed [17:0]      wsum;
  logic signed [ACC_W-1:0] mix_sum;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample_out = out_r;

  assign rate_c  = pot_clamp(rate_r);
  assign depth_c = pot_clamp(depth_r);
  assign mix_c   = pot_clamp(mix_r);

  assign ram_we    = in_acc;
  assign i1        = (i0_r == ADDR_W'(LINE_DEPTH - 1)) ? '0 : i0_r + 1'b1;
  assign ram_raddr = (state_r == S_RD1) ? i1 : i0_r;

  vdl_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_ch.sample_in),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer and serial datapath
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    full_nxt      = full_r;
    phase_nxt     = phase_r;
    mode_nxt      = mode_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    dry_nxt       = dry_r;
    neg_nxt       = neg_r;
    acc_nxt       = acc_r;
    mcand_nxt     = mcand_r;
    dmc_nxt       = dmc_r;
    mplier_nxt    = mplier_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    dly_nxt       = dly_r;
    i0_nxt        = i0_r;
    frac_nxt      = frac_r;
    v_nxt         = v_r;
    s0_nxt        = s0_r;
    out_nxt       = out_r;

    quad    = phase_r[31:30];
    sidx    = quad[0] ? (SINE_IDX_W+1)'(SINE_DEPTH) - {1'b0, phase_r[29 -: SINE_IDX_W]}
                      : {1'b0, phase_r[29 -: SINE_IDX_W]};
    dvs     = sel_r ? DVS_W'(MIX_DEN) : DVS_W'(SW_DEN);
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    swing   = DLY_W'(quo_r);
    dly_raw = neg_r ? DLY_CENTER - swing : DLY_CENTER + swing;
    pos     = $signed({2'b00, wp_r, 16'h0000}) - dly_r;
    s1v     = v_r ? $signed(ram_rdata) : 16'sd0;
    diff    = 17'(s1v) - 17'(s0_r);
    rnd     = acc_r + ACC_W'(32768);
    wsum    = 18'(s0_r) + $signed(rnd[16 +: 18]);
    mix_sum = acc_r + ACC_W'(MIX_BIAS);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          dry_nxt   = in_ch.sample_in;
          phase_nxt = phase_r + INC_TAB[rate_c];
          state_nxt = S_SINE;
        end
      end
      // Sine lookup of the new phase, set up swing multiply
      S_SINE: begin
        neg_nxt    = quad[1];
        mcand_nxt  = ACC_W'(depth_c) * ACC_W'(SW_NUM);
        mplier_nxt = MPL_W'(SINE_TAB[sidx]);
        acc_nxt    = '0;
        cnt_nxt    = CNT_W'(MPL_W);
        mode_nxt   = 1'b0;
        state_nxt  = S_MUL;
      end
      // Shift-add multiply, one multiplier bit per cycle
      S_MUL: begin
        if (cnt_r != '0) begin
          if (mplier_r[0]) begin
            acc_nxt = acc_r + mcand_r;
          end
          mcand_nxt  = mcand_r <<< 1;
          mplier_nxt = mplier_r >> 1;
          cnt_nxt    = cnt_r - 1'b1;
        end else if (mode_r) begin
          state_nxt = S_WET;
        end else begin
          quo_nxt   = acc_r[DIV_W-1:0];
          rem_nxt   = '0;
          sel_nxt   = 1'b0;
          cnt_nxt   = CNT_W'(DIV_W);
          state_nxt = S_DIV;
        end
      end
      // Restoring divide, one quotient bit per cycle
      S_DIV: begin
        if (cnt_r != '0) begin
          if (rem_sh >= {1'b0, dvs}) begin
            rem_nxt = DVS_W'(rem_sh - {1'b0, dvs});
            quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[DVS_W-1:0];
            quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
          end
          cnt_nxt = cnt_r - 1'b1;
        end else if (sel_r) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DLY;
        end
      end
      // Delay = center +- swing, clamped
      S_DLY: begin
        if (dly_raw < DLY_MIN) begin
          dly_nxt = DLY_MIN;
        end else if (dly_raw > DLY_MAX) begin
          dly_nxt = DLY_MAX;
        end else begin
          dly_nxt = dly_raw;
        end
        state_nxt = S_PTR;
      end
      // Read position behind the write pointer
      S_PTR: begin
        if (pos < 0) begin
          i0_nxt   = ADDR_W'((pos + DLY_WRAP) >>> 16);
          frac_nxt = 16'(pos + DLY_WRAP);
        end else begin
          i0_nxt   = ADDR_W'(pos >>> 16);
          frac_nxt = 16'(pos);
        end
        state_nxt = S_RD0;
      end
      // Taps never written since reset read as zero
      S_RD0: begin
        v_nxt     = full_r || (i0_r <= wp_r);
        state_nxt = S_RD1;
      end
      S_RD1: begin
        s0_nxt    = v_r ? $signed(ram_rdata) : 16'sd0;
        v_nxt     = full_r || (i1 <= wp_r);
        state_nxt = S_RD2;
      end
      // wet = s0 + (s1 - s0) * frac / 65536, set up multiply
      S_RD2: begin
        mcand_nxt  = ACC_W'(diff);
        mplier_nxt = frac_r;
        acc_nxt    = '0;
        cnt_nxt    = CNT_W'(MPL_W);
        mode_nxt   = 1'b1;
        state_nxt  = S_MUL;
      end
      // Round the interpolation; load mix multiply.
      // mplier bit 0 walks mix, bit 8 walks 100-mix; 7 steps keep them apart.
      S_WET: begin
        mcand_nxt  = ACC_W'($signed(wsum[15:0]));
        dmc_nxt    = ACC_W'(dry_r);
        mplier_nxt = {1'b0, POT_MAX - mix_c, 1'b0, mix_c};
        acc_nxt    = '0;
        cnt_nxt    = CNT_W'(POT_W);
        state_nxt  = S_MIX;
      end
      S_MIX: begin
        if (cnt_r != '0) begin
          acc_nxt = acc_r + (mplier_r[0] ? mcand_r : '0) + (mplier_r[8] ? dmc_r : '0);
          mcand_nxt  = mcand_r <<< 1;
          dmc_nxt    = dmc_r <<< 1;
          mplier_nxt = mplier_r >> 1;
          cnt_nxt    = cnt_r - 1'b1;
        end else begin
          quo_nxt   = mix_sum[DIV_W-1:0];
          rem_nxt   = '0;
          sel_nxt   = 1'b1;
          cnt_nxt   = CNT_W'(DIV_W);
          state_nxt = S_DIV;
        end
      end
      // Output word, remove the bias, advance the write pointer
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = {~quo_r[15], quo_r[14:0]};
          out_valid_nxt = 1'b1;
          if (wp_r == ADDR_W'(LINE_DEPTH - 1)) begin
            wp_nxt   = '0;
            full_nxt = 1'b1;
          end else begin
            wp_nxt = wp_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      full_r      <= 1'b0;
      phase_r     <= '0;
      rate_r      <= '0;
      depth_r     <= '0;
      mix_r       <= MIX_RESET;
      mode_r      <= 1'b0;
      sel_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      full_r      <= full_nxt;
      phase_r     <= phase_nxt;
      mode_r      <= mode_nxt;
      sel_r       <= sel_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.addr)
          CFG_RATE:  rate_r  <= cfg_ch.wdata;
          CFG_DEPTH: depth_r <= cfg_ch.wdata;
          CFG_MIX:   mix_r   <= cfg_ch.wdata;
          default: begin
          end
        endcase
      end
    end
    dry_r    <= dry_nxt;
    neg_r    <= neg_nxt;
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    dmc_r    <= dmc_nxt;
    mplier_r <= mplier_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    dly_r    <= dly_nxt;
    i0_r     <= i0_nxt;
    frac_r   <= frac_nxt;
    v_r      <= v_nxt;
    s0_r     <= s0_nxt;
    out_r    <= out_nxt;
  end

endmodule

@@ tb/sv/vibrato_delay_line_tb.sv @@
// Testbench for vibrato_delay_line: directed table then random audio words,
// each result checked against a local model of the modulated delay line.
// Depends on vdl_pkg and vdl_if.
`timescale 1ns / 100ps

module vibrato_delay_line_tb;
  import vdl_pkg::*;

  logic clk;
  logic rst_n;

  vdl_in_if  in_ch ();
  vdl_out_if out_ch ();
  vdl_cfg_if cfg_ch ();

  vibrato_delay_line dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Model state
  logic signed [15:0] line_mem [LINE_DEPTH];
  logic [ADDR_W-1:0]  wr_ptr;
  logic [31:0]        phase;
  logic [POT_W-1:0]   rate_reg, depth_reg, mix_reg;
  int                 sine_q [0:SINE_DEPTH];

  logic signed [15:0] expected_q [$];
  int  mismatches;
  bit  rx_stall_en;

  // Quarter sine table, Q30 Taylor series
  task automatic build_sine_q();
    longint unsigned x, x2, t, s;
    longint unsigned dv [5];
    dv = '{110, 72, 42, 20, 6};
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x  = (64'd1686629713 * longint'(k)) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = 64'd1073741824;
      for (int n = 0; n < 5; n++) t = 64'd1073741824 - (((x2 * t) >> 30) / dv[n]);
      s = (x * t) >> 30;
      s = (s * 32767 + (64'd1 << 29)) >> 30;
      if (s > 32767) s = 32767;
      sine_q[k] = int'(s);
    end
  endtask

  function automatic int lfo_sin(logic [31:0] ph);
    int idx;
    int v;
    idx = int'((longint'(ph[29:0]) * SINE_DEPTH) >> 30);
    if (ph[30]) idx = SINE_DEPTH - idx;
    v = sine_q[idx];
    return ph[31] ? -v : v;
  endfunction

  function automatic longint lim(logic [POT_W-1:0] p);
    return (p > 100) ? 100 : longint'(p);
  endfunction

  // One audio word through the vibrato model
  function automatic logic signed [15:0] vibrato_out(logic signed [15:0] dry);
    longint dly, pos, acc, sum, wet, res;
    longint unsigned inc;
    int i0, i1, frac;
    line_mem[wr_ptr] = dry;
    inc = ((longint'(50 + 8 * lim(rate_reg)) << 32) + 2400000) / 4800000;
    phase = phase + 32'(inc);
    dly = (longint'(10) * 48000 * 65536) / 2000;
    dly += (lim(depth_reg) * 48000 * lfo_sin(phase)) / 25000;
    if (dly < 65536) dly = 65536;
    if (dly > longint'(LINE_DEPTH - 2) * 65536) dly = longint'(LINE_DEPTH - 2) * 65536;
    pos = longint'(wr_ptr) * 65536 - dly;
    if (pos < 0) pos += longint'(LINE_DEPTH) * 65536;
    i0 = int'(pos >> 16) % LINE_DEPTH;
    frac = int'(pos & 16'hFFFF);
    i1 = (i0 + 1) % LINE_DEPTH;
    acc = longint'(line_mem[i0]) * (65536 - frac) + longint'(line_mem[i1]) * frac;
    wet = ((acc + 64'sd2147483648 + 32768) >>> 16) - 32768;
    sum = longint'(dry) * (100 - lim(mix_reg)) + wet * lim(mix_reg);
    res = (sum + 3276850) / 100 - 32768;
    if (res > 32767) res = 32767;
    if (res < -32768) res = -32768;
    wr_ptr = wr_ptr + 1'b1;
    return 16'(res);
  endfunction

  task automatic write_pot(logic [CFG_ADDR_W-1:0] a, logic [POT_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= a;
    cfg_ch.wdata <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (a)
      CFG_RATE:  rate_reg  = d;
      CFG_DEPTH: depth_reg = d;
      CFG_MIX:   mix_reg   = d;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Send one word; 'has_fixed' marks a typed-in result given in 'fixed'
  task automatic send_word(logic signed [15:0] s, bit has_fixed, logic signed [15:0] fixed);
    logic signed [15:0] e;
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= s;
    do @(posedge clk); while (!in_ch.ready);
    e = vibrato_out(s);
    if (has_fixed && e != fixed) begin
      $display("table row disagrees with model: row %0d model %0d", fixed, e);
      mismatches++;
    end
    expected_q.push_back(e);
  endtask

  task automatic drain_and_idle();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Result checker, receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %0d", out_ch.sample_out);
        end else begin
          if (out_ch.sample_out !== expected_q[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("sample_out: expected %0d actual %0d", expected_q[0], out_ch.sample_out);
          end
          void'(expected_q.pop_front());
        end
      end
      out_ch.ready <= rx_stall_en ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  typedef struct {
    logic signed [15:0] s;
    bit                 fixed;
    logic signed [15:0] res;
  } stim_row_t;

  stim_row_t dir_tab [] = '{
    '{16'sh7FFF, 1, 16'sd16384}, '{16'sh8000, 1, -16'sd16384}, '{16'sh0000, 1, 16'sd0},
    '{16'sh0001, 1, 16'sd1}, '{16'shFFFF, 1, 16'sd0}, '{16'sh5555, 0, 0},
    '{16'shAAAA, 0, 0}, '{16'sh1234, 0, 0}, '{16'shEDCB, 0, 0}, '{16'sh7FFE, 0, 0}
  };

  initial begin
    int burst;
    in_ch.valid = 1'b0; in_ch.sample_in = '0;
    cfg_ch.valid = 1'b0; cfg_ch.addr = CFG_RATE; cfg_ch.wdata = '0;
    rx_stall_en = 1'b0;
    mismatches = 0;
    build_sine_q();
    foreach (line_mem[i]) line_mem[i] = '0;
    wr_ptr = '0; phase = '0;
    rate_reg = '0; depth_reg = '0; mix_reg = MIX_RESET;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, then extremes of every pot
    foreach (dir_tab[i]) send_word(dir_tab[i].s, dir_tab[i].fixed, dir_tab[i].res);
    drain_and_idle();
    write_pot(CFG_RATE, 7'd100); write_pot(CFG_DEPTH, 7'd100); write_pot(CFG_MIX, 7'd100);
    for (int i = 0; i < 6; i++) send_word(i[0] ? 16'sh7FFF : 16'sh8000, 0, 0);
    drain_and_idle();
    // pots above full scale, and the unused register index
    write_pot(CFG_RATE, 7'd127); write_pot(CFG_DEPTH, 7'd127); write_pot(CFG_MIX, 7'd0);
    write_pot(2'd3, 7'd55);
    for (int i = 0; i < 6; i++) send_word(16'($urandom), 0, 0);
    drain_and_idle();

    // Random phases with fresh settings
    rx_stall_en = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      write_pot(CFG_RATE, 7'($urandom_range(0, 127)));
      write_pot(CFG_DEPTH, (ph == 0) ? 7'd100 : 7'($urandom_range(0, 127)));
      write_pot(CFG_MIX, (ph == 1) ? 7'd100 : 7'($urandom_range(0, 127)));
      for (int n = 0; n < 300; ) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && n < 300; b++, n++) send_word(16'($urandom), 0, 0);
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 150)) @(posedge clk);
      end
      rx_stall_en = (ph % 2 == 0);
      drain_and_idle();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hard timeout
  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
